// ===== rtl/line_buffer_conv2d_unit_defines.svh =====
// Assertion macros shared by the line buffer convolution RTL.
`ifndef LINE_BUFFER_CONV2D_UNIT_DEFINES_SVH
`define LINE_BUFFER_CONV2D_UNIT_DEFINES_SVH
`ifndef ASSERT_OFF
`define LBC_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("lbc assertion failed");
`define LBC_ASSERT_NEXT(lbl, clk, rst_n, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("lbc assertion failed");
`else
`define LBC_ASSERT(lbl, clk, rst_n, prop)
`define LBC_ASSERT_NEXT(lbl, clk, rst_n, pre, post)
`endif
`endif

// ===== rtl/lbc_pkg.sv =====
// Package: constants and types for the line buffer convolution unit.
`timescale 1ns / 1ps
package lbc_pkg;
    localparam int KERNEL_SIZE_DEF = 3;
    localparam int MAX_WIDTH_DEF   = 1024;
    localparam int VALUE_W = 16;
    localparam int PROD_W  = 32;
    localparam int SUM_W   = 38;
    localparam int COL_W   = 10;
    localparam int IDX_W   = 6;
    localparam int CFG_W   = 11;
    localparam logic [CFG_W-1:0] WIDTH_RESET = 11'd1024;

    localparam logic OP_COEF  = 1'b0;
    localparam logic OP_PIXEL = 1'b1;

    typedef struct packed {
        logic                      op;
        logic [IDX_W-1:0]          coef_index;
        logic signed [VALUE_W-1:0] value;
        logic [COL_W-1:0]          col;
        logic                      emit;
    } t_item;
endpackage

// ===== rtl/line_buffer_conv2d_unit.sv =====
// Top level of the line buffer 2D convolution unit.
// Streaming KERNEL_SIZE x KERNEL_SIZE window correlation: one transaction (pixel
// or coefficient) is taken per clock while o_stall is low. A front section
// tracks the image column and feeds a four-entry queue; the back section reads
// and rewrites one line store word per pixel (one read and one write port of
// the line RAM, so one pixel per cycle while the output is not stalled) and
// runs a multiply, column-sum, total-sum pipeline. The line store holds no
// reset value and needs no clearing pass.
`timescale 1ns / 1ps
module line_buffer_conv2d_unit import lbc_pkg::*; #(
    parameter int KERNEL_SIZE = KERNEL_SIZE_DEF,
    parameter int MAX_WIDTH   = MAX_WIDTH_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_wr_en,
    input  logic [CFG_W-1:0]          i_cfg_wr_data,
    input  logic                      i_valid,
    output logic                      o_stall,
    input  logic                      i_op,
    input  logic [IDX_W-1:0]          i_coef_index,
    input  logic signed [VALUE_W-1:0] i_value,
    input  logic                      i_frame_start,
    output logic                      o_valid,
    input  logic                      i_stall,
    output logic signed [SUM_W-1:0]   o_window_sum,
    output logic [COL_W-1:0]          o_out_column
);
    t_item item, head;
    logic  accept, full, empty, pop;

    assign accept  = i_valid && !full;
    assign o_stall = full;

    lbc_front #(.KERNEL_SIZE(KERNEL_SIZE), .MAX_WIDTH(MAX_WIDTH)) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_accept      (accept),
        .i_op          (i_op),
        .i_coef_index  (i_coef_index),
        .i_value       (i_value),
        .i_frame_start (i_frame_start),
        .o_item        (item)
    );

    lbc_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_data  (item),
        .i_pop   (pop),
        .o_head  (head),
        .o_full  (full),
        .o_empty (empty)
    );

    lbc_back #(.KERNEL_SIZE(KERNEL_SIZE), .MAX_WIDTH(MAX_WIDTH)) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (head),
        .i_empty      (empty),
        .o_pop        (pop),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_window_sum (o_window_sum),
        .o_out_column (o_out_column)
    );
endmodule

// ===== rtl/lbc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module lbc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ===== rtl/lbc_fifo.sv =====
// Short transaction queue between the front and back sections.
`timescale 1ns / 1ps
`include "line_buffer_conv2d_unit_defines.svh"
module lbc_fifo import lbc_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_data,
    input  logic  i_pop,
    output t_item o_head,
    output logic  o_full,
    output logic  o_empty
);
    localparam int DEPTH = 4;
    localparam int AW    = $clog2(DEPTH);

    t_item          r_mem [DEPTH];
    logic [AW-1:0]  r_wp, r_rp;
    logic [AW:0]    r_cnt;

    assign o_full  = (r_cnt == (AW+1)'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    `LBC_ASSERT(a_no_overflow, i_clk, i_rst_n, o_full |-> !i_push)
    `LBC_ASSERT(a_no_underflow, i_clk, i_rst_n, o_empty |-> !i_pop)
    `LBC_ASSERT(a_cnt_bound, i_clk, i_rst_n, r_cnt <= (AW+1)'(DEPTH))
endmodule

// ===== rtl/lbc_front.sv =====
// Front section: takes transactions, tracks the column and tags emitting pixels.
`timescale 1ns / 1ps
module lbc_front import lbc_pkg::*; #(
    parameter int KERNEL_SIZE = KERNEL_SIZE_DEF,
    parameter int MAX_WIDTH   = MAX_WIDTH_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_wr_en,
    input  logic [CFG_W-1:0]          i_cfg_wr_data,
    input  logic                      i_accept,
    input  logic                      i_op,
    input  logic [IDX_W-1:0]          i_coef_index,
    input  logic signed [VALUE_W-1:0] i_value,
    input  logic                      i_frame_start,
    output t_item                     o_item
);
    logic [CFG_W-1:0] r_width;
    logic [COL_W-1:0] r_col, n_col;
    logic [CFG_W-1:0] width_eff;
    logic [COL_W-1:0] cur_col;

    always_comb begin
        if (32'(r_width) > MAX_WIDTH) begin
            width_eff = CFG_W'(MAX_WIDTH);
        end else if (r_width == '0) begin
            width_eff = CFG_W'(1);
        end else begin
            width_eff = r_width;
        end
        cur_col = i_frame_start ? '0 : r_col;
        if (32'(cur_col) >= MAX_WIDTH) begin
            cur_col = '0;
        end
        // row ends once the next column reaches the active width
        if (({2'b00, cur_col} + 12'd1) >= {1'b0, width_eff}) begin
            n_col = '0;
        end else begin
            n_col = cur_col + 1'b1;
        end
        o_item.op         = i_op;
        o_item.coef_index = i_coef_index;
        o_item.value      = i_value;
        o_item.col        = cur_col;
        o_item.emit       = (32'(cur_col) >= KERNEL_SIZE - 1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width <= WIDTH_RESET;
            r_col   <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_width <= i_cfg_wr_data;
            end
            if (i_accept && i_op == OP_PIXEL) begin
                r_col <= n_col;
            end
        end
    end
endmodule

// ===== rtl/lbc_back.sv =====
// Back section: line store, window shift, coefficient store and the MAC pipeline.
`timescale 1ns / 1ps
`include "line_buffer_conv2d_unit_defines.svh"
module lbc_back import lbc_pkg::*; #(
    parameter int KERNEL_SIZE = KERNEL_SIZE_DEF,
    parameter int MAX_WIDTH   = MAX_WIDTH_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_item                   i_head,
    input  logic                    i_empty,
    output logic                    o_pop,
    output logic                    o_valid,
    input  logic                    i_stall,
    output logic signed [SUM_W-1:0] o_window_sum,
    output logic [COL_W-1:0]        o_out_column
);
    localparam int K     = KERNEL_SIZE;
    localparam int KK    = K * K;
    localparam int AW    = $clog2(MAX_WIDTH);
    localparam int CIW   = $clog2(KK);
    localparam int RW    = K * VALUE_W;
    localparam int CSUM_W = PROD_W + $clog2(K) + 1;

    logic en;
    logic [RW-1:0] ram_rdata, fresh, new_word;

    t_item         r_s1;
    logic          r_s1_v, r_s1_fwd;
    logic [RW-1:0] r_s1_fwd_data;

    logic signed [VALUE_W-1:0] r_win [K][K];
    logic signed [VALUE_W-1:0] r_coef [KK];

    logic                      r_s2_v, r_s3_v, r_s4_v, r_out_valid;
    logic [COL_W-1:0]          r_s2_col, r_s3_col, r_s4_col, r_out_col;
    logic signed [PROD_W-1:0]  r_s3_prod [K][K];
    logic signed [CSUM_W-1:0]  r_s4_csum [K];
    logic signed [SUM_W-1:0]   r_out_sum, total;
    logic signed [CSUM_W-1:0]  csum [K];

    logic s1_pix, wr_line;

    assign en     = !(r_out_valid && i_stall);
    assign o_pop  = en && !i_empty;
    assign s1_pix = r_s1_v && (r_s1.op == OP_PIXEL);
    assign wr_line = en && s1_pix;

    lbc_ram #(.WIDTH(RW), .DEPTH(MAX_WIDTH)) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (wr_line),
        .i_waddr (AW'(r_s1.col)),
        .i_wdata (new_word),
        .i_re    (en),
        .i_raddr (AW'(i_head.col)),
        .o_rdata (ram_rdata)
    );

    // stored column moves up one row, new pixel goes to the bottom row
    always_comb begin
        fresh = r_s1_fwd ? r_s1_fwd_data : ram_rdata;
        for (int h = 0; h < K - 1; h++) begin
            new_word[h*VALUE_W +: VALUE_W] = fresh[(h+1)*VALUE_W +: VALUE_W];
        end
        new_word[(K-1)*VALUE_W +: VALUE_W] = r_s1.value;
    end

    always_comb begin
        for (int w = 0; w < K; w++) begin
            csum[w] = '0;
            for (int h = 0; h < K; h++) begin
                csum[w] = csum[w] + CSUM_W'(r_s3_prod[w][h]);
            end
        end
        total = '0;
        for (int w = 0; w < K; w++) begin
            total = total + SUM_W'(r_s4_csum[w]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v      <= 1'b0;
            r_s2_v      <= 1'b0;
            r_s3_v      <= 1'b0;
            r_s4_v      <= 1'b0;
            r_out_valid <= 1'b0;
            for (int a = 0; a < K; a++) begin
                for (int h = 0; h < K; h++) begin
                    r_win[a][h] <= '0;
                end
            end
            for (int i = 0; i < KK; i++) begin
                r_coef[i] <= '0;
            end
        end else if (en) begin
            r_s1_v      <= o_pop;
            r_s2_v      <= s1_pix && r_s1.emit;
            r_s3_v      <= r_s2_v;
            r_s4_v      <= r_s3_v;
            r_out_valid <= r_s4_v;
            if (s1_pix) begin
                for (int a = K - 1; a > 0; a--) begin
                    r_win[a] <= r_win[a-1];
                end
                for (int h = 0; h < K; h++) begin
                    r_win[0][h] <= fresh[h*VALUE_W +: VALUE_W];
                end
            end
            if (r_s1_v && r_s1.op == OP_COEF && 32'(r_s1.coef_index) < KK) begin
                r_coef[CIW'(r_s1.coef_index)] <= r_s1.value;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1 <= i_head;
            // RAM reads old data when the same column is written in this cycle
            r_s1_fwd      <= s1_pix && o_pop && (r_s1.col == i_head.col);
            r_s1_fwd_data <= new_word;
            r_s2_col <= r_s1.col;
            r_s3_col <= r_s2_col;
            for (int w = 0; w < K; w++) begin
                for (int h = 0; h < K; h++) begin
                    r_s3_prod[w][h] <= r_win[K-1-w][h] * r_coef[w*K+h];
                end
            end
            r_s4_col <= r_s3_col;
            r_s4_csum <= csum;
            r_out_col <= r_s4_col;
            r_out_sum <= total;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_window_sum = r_out_sum;
    assign o_out_column = r_out_col;

    `LBC_ASSERT(a_emit_col, i_clk, i_rst_n, r_s2_v |-> (32'(r_s2_col) >= K - 1))
    `LBC_ASSERT(a_fwd_needs_item, i_clk, i_rst_n, r_s1_fwd |-> r_s1_v)
    `LBC_ASSERT_NEXT(a_hold_on_stall, i_clk, i_rst_n, !en, $stable(r_s4_v) && $stable(r_s1_v))
endmodule
